@@ hdl/alarm_clock_display_controller_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef ALARM_CLOCK_DISPLAY_CONTROLLER_DEFINES_SVH
`define ALARM_CLOCK_DISPLAY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ACD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ACD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/acd_pkg.sv @@
package acd_pkg;

	typedef struct packed {
		logic [2:0]  operation;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [31:0] now_ms;
	} acd_in_t;

	typedef struct packed {
		logic       segments_valid;
		logic [7:0] digit0;
		logic [7:0] digit1;
		logic [7:0] digit2;
		logic [7:0] digit3;
		logic       buzzer;
		logic       alarm_sounding;
		logic [1:0] display_mode;
		logic [1:0] status;
	} acd_out_t;

	// Configuration port.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TWELVE_HOUR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_DURATION  = 3'd5;

	localparam logic [15:0] MSG_DURATION_RESET = 16'd3000;

	// Operation codes.
	localparam logic [2:0] OP_REFRESH    = 3'd0;
	localparam logic [2:0] OP_CLICK      = 3'd1;
	localparam logic [2:0] OP_LONG_PRESS = 3'd2;
	localparam logic [2:0] OP_REMOTE_ON  = 3'd3;
	localparam logic [2:0] OP_REMOTE_OFF = 3'd4;
	localparam logic [2:0] OP_STATUS     = 3'd5;

	// Display modes.
	localparam logic [1:0] MODE_CLOCK = 2'd0;
	localparam logic [1:0] MODE_ALARM = 2'd1;
	localparam logic [1:0] MODE_ON    = 2'd2;
	localparam logic [1:0] MODE_OFF   = 2'd3;

	// Status codes.
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_ALREADY_ON  = 2'd1;
	localparam logic [1:0] STATUS_ALREADY_OFF = 2'd2;

	// Segment bits, bit0 is segment a.
	localparam logic [7:0] SEG_A     = 8'h01;
	localparam logic [7:0] SEG_C     = 8'h04;
	localparam logic [7:0] SEG_E     = 8'h10;
	localparam logic [7:0] SEG_F     = 8'h20;
	localparam logic [7:0] SEG_G     = 8'h40;
	localparam logic [7:0] COLON_BIT = 8'd128;

	localparam logic [4:0]  HOUR_HALF      = 5'd12;
	localparam logic [16:0] LAST_TIME_NONE = 17'h1FFFF;

endpackage

@@ hdl/alarm_clock_display_controller.sv @@
// Alarm clock display controller. Each transfer on the input channel is one event: a
// refresh with the time of day, a button click, a long press, or a remote alarm on,
// off or status command, each with a millisecond stamp. Every event yields exactly one
// result: four segment bytes (bit0 segment a to bit6 g, bit7 of digit1 the colon) when
// something was drawn, the buzzer pin, the alarm flag, the display mode and a status
// code. The block takes one event per clock cycle unless the output stalls. An event is
// held in the input register, and its result is then registered in the result
// register, from which it is presented. All mode, alarm and drawing logic is combinational
// between the two registers. A stall on the output holds the result register and then
// the input register. Configuration registers are written by index and must only change
// while idle.
module alarm_clock_display_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  acd_pkg::acd_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output acd_pkg::acd_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [acd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acd_pkg::*;

	function automatic logic [7:0] seg_font(input logic [3:0] d);
		logic [7:0] f;
		case (d)
			4'd0: f = 8'h3F;
			4'd1: f = 8'h06;
			4'd2: f = 8'h5B;
			4'd3: f = 8'h4F;
			4'd4: f = 8'h66;
			4'd5: f = 8'h6D;
			4'd6: f = 8'h7D;
			4'd7: f = 8'h07;
			4'd8: f = 8'h7F;
			4'd9: f = 8'h6F;
			default: f = 8'h00;
		endcase
		return f;
	endfunction

	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd60)      t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	// Remainder after removing t tens: v - 8t - 2t.
	function automatic logic [3:0] units_of(input logic [5:0] v, input logic [2:0] t);
		logic [5:0] r;
		r = v - {t, 3'b000} - {2'b00, t, 1'b0};
		return r[3:0];
	endfunction

	function automatic logic [31:0] draw_time(input logic [4:0] h_in, input logic [5:0] m_in,
			input logic colon, input logic twelve);
		logic [4:0] h;
		logic [2:0] ht;
		logic [2:0] mt;
		logic [3:0] hu;
		logic [3:0] mu;
		logic [7:0] d0;
		logic [7:0] d1;
		h  = (twelve && (h_in > HOUR_HALF)) ? (h_in - HOUR_HALF) : h_in;
		ht = tens_of({1'b0, h});
		hu = units_of({1'b0, h}, ht);
		mt = tens_of(m_in);
		mu = units_of(m_in, mt);
		d0 = (h >= 5'd10) ? seg_font({1'b0, ht}) : 8'h00;
		d1 = seg_font(hu) | (colon ? COLON_BIT : 8'h00);
		return {d0, d1, seg_font({1'b0, mt}), seg_font(mu)};
	endfunction

	// Configuration registers.
	logic        alarm_enabled_q;
	logic [4:0]  alarm_hour_q;
	logic [5:0]  alarm_minute_q;
	logic        blink_enable_q;
	logic        twelve_hour_q;
	logic [15:0] msg_duration_q;

	// Controller state.
	logic [1:0]  mode_q;
	logic        alarm_flag_q;
	logic        buzzer_level_q;
	logic        buzzer_pin_q;
	logic        colon_phase_q;
	logic [16:0] last_time_q;
	logic [31:0] msg_start_q;

	// Input register and result register.
	logic        valid_s1;
	acd_in_t     data_s1;
	logic        out_valid_q;
	acd_out_t    out_q;

	logic        advance;

	logic [1:0]  nxt_mode;
	logic        nxt_flag;
	logic        nxt_level;
	logic        nxt_pin;
	logic        nxt_colon;
	logic [16:0] nxt_last;
	logic [31:0] nxt_start;
	logic        seg_valid;
	logic [31:0] digits;
	logic [1:0]  status;
	logic [16:0] packed_time;
	logic [31:0] elapsed;
	logic        msg_live;
	logic        fire;

	// The input register moves on when the result register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign packed_time = {data_s1.hours, data_s1.minutes, data_s1.seconds};
	assign elapsed     = data_s1.now_ms - msg_start_q;
	assign msg_live    = elapsed < {16'd0, msg_duration_q};
	assign fire = (packed_time != last_time_q) && (data_s1.seconds == 6'd0) && alarm_enabled_q
		&& !alarm_flag_q && (alarm_hour_q == data_s1.hours) && (alarm_minute_q == data_s1.minutes);

	always_comb begin
		nxt_mode  = mode_q;
		nxt_flag  = alarm_flag_q;
		nxt_level = buzzer_level_q;
		nxt_pin   = buzzer_pin_q;
		nxt_colon = colon_phase_q;
		nxt_last  = last_time_q;
		nxt_start = msg_start_q;
		seg_valid = 1'b0;
		digits    = 32'd0;
		status    = STATUS_OK;
		case (data_s1.operation)
			OP_REFRESH: begin
				if (mode_q == MODE_CLOCK) begin
					// The firing refresh still shows the time, then the on message follows.
					if (fire) begin
						nxt_flag  = 1'b1;
						nxt_level = 1'b1;
						nxt_mode  = MODE_ON;
						nxt_start = data_s1.now_ms;
					end
					digits    = draw_time(data_s1.hours, data_s1.minutes, colon_phase_q,
						twelve_hour_q);
					seg_valid = 1'b1;
					nxt_colon = blink_enable_q ? ~colon_phase_q : 1'b1;
					nxt_last  = packed_time;
				end else if (!msg_live) begin
					nxt_mode = MODE_CLOCK;
				end else if (mode_q == MODE_ALARM) begin
					digits    = draw_time(alarm_hour_q, alarm_minute_q, 1'b1, twelve_hour_q);
					seg_valid = 1'b1;
				end else if (mode_q == MODE_ON) begin
					digits    = {seg_font(4'd0), SEG_C | SEG_E | SEG_G, 16'd0};
					seg_valid = 1'b1;
				end else begin
					digits    = {seg_font(4'd0), SEG_A | SEG_E | SEG_F | SEG_G,
						SEG_A | SEG_E | SEG_F | SEG_G, 8'd0};
					seg_valid = 1'b1;
				end
				if (nxt_flag) begin
					nxt_level = ~nxt_level;
					nxt_pin   = nxt_level;
				end else if (nxt_level) begin
					nxt_pin = 1'b0;
				end
			end
			OP_CLICK: begin
				if (alarm_flag_q) begin
					nxt_flag  = 1'b0;
					nxt_mode  = MODE_OFF;
					nxt_start = data_s1.now_ms;
				end
			end
			OP_LONG_PRESS: begin
				nxt_mode  = MODE_ALARM;
				nxt_start = data_s1.now_ms;
			end
			OP_REMOTE_ON: begin
				if (!alarm_flag_q) begin
					nxt_flag  = 1'b1;
					nxt_mode  = MODE_ON;
					nxt_start = data_s1.now_ms;
				end else begin
					status = STATUS_ALREADY_ON;
				end
			end
			OP_REMOTE_OFF: begin
				if (alarm_flag_q) begin
					nxt_flag  = 1'b0;
					nxt_mode  = MODE_OFF;
					nxt_start = data_s1.now_ms;
				end else begin
					status = STATUS_ALREADY_OFF;
				end
			end
			OP_STATUS: begin
				status = STATUS_OK;
			end
			default: begin
				status = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_enabled_q <= 1'b0;
			alarm_hour_q    <= 5'd0;
			alarm_minute_q  <= 6'd0;
			blink_enable_q  <= 1'b0;
			twelve_hour_q   <= 1'b0;
			msg_duration_q  <= MSG_DURATION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALARM_ENABLED: alarm_enabled_q <= cfg_data[0];
				CFG_ALARM_HOUR:    alarm_hour_q    <= cfg_data[4:0];
				CFG_ALARM_MINUTE:  alarm_minute_q  <= cfg_data[5:0];
				CFG_BLINK_ENABLE:  blink_enable_q  <= cfg_data[0];
				CFG_TWELVE_HOUR:   twelve_hour_q   <= cfg_data[0];
				CFG_MSG_DURATION:  msg_duration_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_CLOCK;
			alarm_flag_q   <= 1'b0;
			buzzer_level_q <= 1'b0;
			buzzer_pin_q   <= 1'b0;
			colon_phase_q  <= 1'b0;
			last_time_q    <= LAST_TIME_NONE;
			msg_start_q    <= 32'd0;
		end else if (advance) begin
			mode_q         <= nxt_mode;
			alarm_flag_q   <= nxt_flag;
			buzzer_level_q <= nxt_level;
			buzzer_pin_q   <= nxt_pin;
			colon_phase_q  <= nxt_colon;
			last_time_q    <= nxt_last;
			msg_start_q    <= nxt_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
		if (advance) begin
			out_q.segments_valid <= seg_valid;
			out_q.digit0         <= digits[31:24];
			out_q.digit1         <= digits[23:16];
			out_q.digit2         <= digits[15:8];
			out_q.digit3         <= digits[7:0];
			out_q.buzzer         <= nxt_pin;
			out_q.alarm_sounding <= nxt_flag;
			out_q.display_mode   <= nxt_mode;
			out_q.status         <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/acd_checker.sv @@
`include "alarm_clock_display_controller_defines.svh"

module acd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input acd_pkg::acd_out_t out_data
);
	import acd_pkg::*;

	// A result held back by the consumer stays in place.
	`ACD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

	// Nothing drawn means all four digit bytes are blank.
	`ACD_ASSERT_IMP(a_blank_digits, out_valid && !out_data.segments_valid, (out_data.digit0 == 8'd0) && (out_data.digit1 == 8'd0) && (out_data.digit2 == 8'd0) && (out_data.digit3 == 8'd0), "undrawn result has lit segments")

	// An already-on report can only come while the alarm sounds.
	`ACD_ASSERT_IMP(a_already_on, out_valid && (out_data.status == STATUS_ALREADY_ON), out_data.alarm_sounding && !out_data.segments_valid, "already-on status without alarm")

	// An already-off report can only come while the alarm is silent.
	`ACD_ASSERT_IMP(a_already_off, out_valid && (out_data.status == STATUS_ALREADY_OFF), !out_data.alarm_sounding && !out_data.segments_valid, "already-off status with alarm")

endmodule

bind alarm_clock_display_controller acd_checker u_acd_checker (.*);
